### hdl/asd_pkg.sv
package asd_pkg;

  localparam int unsigned PosWidth = 17;

  localparam logic [7:0] OP_AUTH_CHALLENGE = 8'h00;
  localparam logic [7:0] OP_AUTH_PROOF     = 8'h01;
  localparam logic [7:0] OP_REALM_LIST     = 8'h10;

  // Challenge packet layout.
  localparam logic [PosWidth-1:0] CHAL_STATUS_POS = 17'd2;
  localparam logic [PosWidth-1:0] CHAL_GEN_POS    = 17'd35;
  localparam logic [PosWidth-1:0] CHAL_GEN_BASE   = 17'd36;
  localparam logic [PosWidth-1:0] CHAL_FAIL_LEN   = 17'd3;
  // 36 + 1 + 32 + 16 + 1 bytes around the two variable fields.
  localparam logic [PosWidth-1:0] CHAL_FIXED_LEN  = 17'd86;

  // Proof packet layout.
  localparam logic [PosWidth-1:0] PROOF_STATUS_POS = 17'd1;
  localparam logic [PosWidth-1:0] PROOF_OK_LEN     = 17'd22;
  localparam logic [PosWidth-1:0] PROOF_FAIL_LEN   = 17'd2;

  // Realm list packet layout.
  localparam logic [PosWidth-1:0] REALM_SIZE_LO_POS = 17'd1;
  localparam logic [PosWidth-1:0] REALM_SIZE_HI_POS = 17'd2;
  localparam logic [PosWidth-1:0] REALM_HDR_LEN     = 17'd3;

  localparam logic [PosWidth-1:0] POS_LIMIT = 17'd65537;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [7:0] opcode;
    logic       locked;
  } asd_result_t;

  typedef struct packed {
    logic                error;
    logic [PosWidth-1:0] position;
  } asd_status_t;

endpackage

### hdl/asd_parser.sv
module asd_parser
  import asd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [7:0]  byte_in,
  output asd_result_t result,
  output asd_status_t status
);

  logic [PosWidth-1:0] byte_position, byte_position_next;
  logic [7:0]          current_opcode, current_opcode_next;
  logic [PosWidth-1:0] expected_length, expected_length_next;
  logic                length_known, length_known_next;
  logic [7:0]          generator_length, generator_length_next;
  logic [7:0]          size_low_byte, size_low_byte_next;
  logic                error_flag, error_flag_next;

  logic [PosWidth-1:0] pos_inc;
  logic [PosWidth-1:0] gen_pos;
  logic                first, last;

  assign pos_inc = byte_position + 17'd1;
  assign gen_pos = CHAL_GEN_BASE + {9'd0, generator_length};

  always_comb begin
    byte_position_next    = byte_position;
    current_opcode_next   = current_opcode;
    expected_length_next  = expected_length;
    length_known_next     = length_known;
    generator_length_next = generator_length;
    size_low_byte_next    = size_low_byte;
    error_flag_next       = error_flag;
    first                 = 1'b0;
    last                  = 1'b0;

    if (!error_flag && byte_position == '0) begin
      if (byte_in == OP_AUTH_CHALLENGE || byte_in == OP_AUTH_PROOF ||
          byte_in == OP_REALM_LIST) begin
        current_opcode_next  = byte_in;
        length_known_next    = 1'b0;
        expected_length_next = '0;
        byte_position_next   = 17'd1;
        first                = 1'b1;
      end else begin
        error_flag_next = 1'b1;
      end
    end else if (!error_flag) begin
      case (current_opcode)
        OP_AUTH_CHALLENGE: begin
          if (byte_position == CHAL_STATUS_POS && byte_in != 8'd0) begin
            expected_length_next = CHAL_FAIL_LEN;
            length_known_next    = 1'b1;
          end else if (byte_position == CHAL_GEN_POS) begin
            generator_length_next = byte_in;
          end else if (byte_position >= CHAL_GEN_BASE && !length_known &&
                       byte_position == gen_pos) begin
            expected_length_next = CHAL_FIXED_LEN + {9'd0, generator_length} +
                                   {9'd0, byte_in};
            length_known_next    = 1'b1;
          end
        end
        OP_AUTH_PROOF: begin
          if (byte_position == PROOF_STATUS_POS) begin
            expected_length_next = (byte_in == 8'd0) ? PROOF_OK_LEN : PROOF_FAIL_LEN;
            length_known_next    = 1'b1;
          end
        end
        default: begin
          if (byte_position == REALM_SIZE_LO_POS) begin
            size_low_byte_next = byte_in;
          end else if (byte_position == REALM_SIZE_HI_POS) begin
            expected_length_next = REALM_HDR_LEN + {1'b0, byte_in, size_low_byte};
            length_known_next    = 1'b1;
          end
        end
      endcase

      if (length_known_next && pos_inc >= expected_length_next) begin
        last               = 1'b1;
        byte_position_next = '0;
      end else begin
        byte_position_next = pos_inc;
      end
    end
  end

  always_comb begin
    result.data = byte_in;
    if (error_flag_next) begin
      result.first  = 1'b0;
      result.last   = 1'b0;
      result.opcode = 8'd0;
      result.locked = 1'b1;
    end else begin
      result.first  = first;
      result.last   = last;
      result.opcode = current_opcode_next;
      result.locked = 1'b0;
    end
  end

  assign status.error    = error_flag;
  assign status.position = byte_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      current_opcode   <= '0;
      expected_length  <= '0;
      length_known     <= 1'b0;
      generator_length <= '0;
      size_low_byte    <= '0;
      error_flag       <= 1'b0;
    end else if (advance) begin
      byte_position    <= byte_position_next;
      current_opcode   <= current_opcode_next;
      expected_length  <= expected_length_next;
      length_known     <= length_known_next;
      generator_length <= generator_length_next;
      size_low_byte    <= size_low_byte_next;
      error_flag       <= error_flag_next;
    end
  end

endmodule

### hdl/auth_stream_deframer.sv
// An accepted input beat is registered and appears as its output beat in the next cycle.
// Throughput: one beat per cycle; the output register is reloaded in the same
// cycle that its beat is taken, so only output backpressure stalls the input.
// Reset (synchronous, active high) clears the parse state, the sticky error
// and the output valid.
module auth_stream_deframer
  import asd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte_out,
  output logic       packet_start,
  output logic       packet_end,
  output logic [7:0] opcode_out,
  output logic       error_locked
);

  asd_result_t result;
  asd_status_t status;
  logic        in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  asd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (in_fire),
    .byte_in (byte_in),
    .result  (result),
    .status  (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_out     <= result.data;
      packet_start <= result.first;
      packet_end   <= result.last;
      opcode_out   <= result.opcode;
      error_locked <= result.locked;
    end
  end

  // Once locked, the parser never leaves the error state.
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    status.error |=> status.error)
    else $error("error flag cleared without reset");

  a_locked_no_marks: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_locked |-> !packet_start && !packet_end && opcode_out == 8'd0)
    else $error("locked beat carries packet marks");

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    status.position <= POS_LIMIT)
    else $error("byte position out of range");

  a_error_freezes_position: assert property (@(posedge clk) disable iff (rst)
    status.error |=> $stable(status.position))
    else $error("byte position moved while locked");

endmodule
